FILE: design/ahs_pkg.sv
`timescale 1ns / 1ps

package ahs_pkg;

  localparam int POSITION_WIDTH     = 32;
  localparam int LONG_SETTLE_TICKS  = 100;
  localparam int SHORT_SETTLE_TICKS = 10;

  localparam int POS_W    = 32;
  localparam int DIFF_W   = 34;
  localparam int CALC_W   = 50;
  localparam int SETTLE_W = 7;
  localparam int CFG_IDX_W = 3;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 48;

  localparam logic signed [CALC_W-1:0] POS_MAX = CALC_W'({1'b0, {(POSITION_WIDTH-1){1'b1}}});
  localparam logic signed [CALC_W-1:0] POS_MIN = -POS_MAX - CALC_W'(1);

  typedef enum logic [2:0] {
    STEP_START  = 3'd0,
    STEP_JOG    = 3'd1,
    STEP_STALL  = 3'd2,
    STEP_STOP   = 3'd3,
    STEP_BACK   = 3'd4,
    STEP_SETTLE = 3'd5,
    STEP_HOME   = 3'd6,
    STEP_IDLE   = 3'd7
  } step_t;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_JOG    = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_MOVE   = 3'd3,
    CMD_PRESET = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCEDURE = 3'd0,
    REG_SEARCH_NEG = 3'd1,
    REG_STALL_THR = 3'd2,
    REG_MATCH_TOL = 3'd3,
    REG_BACKOFF = 3'd4,
    REG_HOME_OFFSET = 3'd5,
    REG_HOME_POSITION = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic              procedure;
    logic              search_negative;
    logic [30:0]       stall_threshold;
    logic [30:0]       match_tolerance;
    logic [30:0]       backoff_distance;
    logic signed [31:0] home_offset;
    logic signed [31:0] home_position;
  } cfg_t;

  typedef struct packed {
    logic               start_req;
    logic signed [31:0] commanded_position;
    logic signed [31:0] measured_position;
    logic signed [31:0] target_position;
    logic               stop_seen;
    logic               stop_done;
  } in_t;

  typedef struct packed {
    step_t              step;
    logic               touch_count;
    logic signed [31:0] first_touch;
    logic [SETTLE_W-1:0] settle_count;
    logic [3:0]         status_flags;
  } state_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] command_value;
    logic               load_params;
    logic               restore_params;
    logic               homed;
    logic               homed_negative;
    logic               homed_positive;
    logic               alarm;
    logic               busy_res;
  } out_t;

  localparam int FL_HOMED = 0;
  localparam int FL_NEG   = 1;
  localparam int FL_POS   = 2;
  localparam int FL_ALARM = 3;

  function automatic logic signed [CALC_W-1:0] sat_pos(logic signed [CALC_W-1:0] v);
    logic signed [CALC_W-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX;
    end else if (v < POS_MIN) begin
      r = POS_MIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: design/ahs_step_logic.sv
`timescale 1ns / 1ps

module ahs_step_logic
  import ahs_pkg::*;
(
  input  cfg_t   cfg,
  input  in_t    word,
  input  state_t cur,
  output state_t nxt,
  output out_t   res
);

  logic signed [CALC_W-1:0] meas_x;
  logic signed [CALC_W-1:0] back_x;
  logic signed [CALC_W-1:0] offs_x;
  logic signed [CALC_W-1:0] back_tgt;
  logic signed [CALC_W-1:0] home_tgt;
  logic signed [DIFF_W-1:0] ferr;
  logic signed [DIFF_W-1:0] thr;
  logic signed [DIFF_W-1:0] tdiff;
  logic signed [DIFF_W-1:0] tol;
  logic                     stalled;
  logic                     mismatch;
  logic [3:0]               side;

  assign meas_x = CALC_W'(word.measured_position);
  assign back_x = CALC_W'({1'b0, cfg.backoff_distance});
  assign offs_x = CALC_W'(cfg.home_offset);
  assign back_tgt = sat_pos(cfg.search_negative ? meas_x + back_x : meas_x - back_x);
  assign home_tgt = sat_pos(cfg.search_negative ? meas_x + offs_x : meas_x - offs_x);
  assign ferr = DIFF_W'(word.commanded_position) - DIFF_W'(word.measured_position);
  assign thr  = DIFF_W'({1'b0, cfg.stall_threshold});
  assign stalled = (ferr >= thr) || (ferr <= -thr);
  assign tdiff = DIFF_W'(word.measured_position) - DIFF_W'(cur.first_touch);
  assign tol   = DIFF_W'({1'b0, cfg.match_tolerance});
  assign mismatch = (tdiff < -tol) || (tdiff > tol);
  assign side = cfg.search_negative ? 4'(1 << FL_NEG) : 4'(1 << FL_POS);

  always_comb begin
    nxt = cur;
    res = '0;
    res.command = CMD_NONE;
    if (cur.settle_count != '0) begin
      nxt.settle_count = cur.settle_count - SETTLE_W'(1);
    end
    if (word.start_req) begin
      nxt.step = STEP_START;
    end
    if (nxt.step == STEP_START) begin
      nxt.status_flags[FL_ALARM] = 1'b0;
      nxt.status_flags = nxt.status_flags & ~(cfg.procedure ? side : 4'(1 << FL_HOMED));
      res.load_params = 1'b1;
      nxt.touch_count = 1'b0;
      nxt.step = STEP_JOG;
    end
    case (nxt.step)
      STEP_JOG: begin
        if (nxt.settle_count == '0) begin
          res.command = CMD_JOG;
          res.command_value = cfg.search_negative ? -32'sd1 : 32'sd1;
          nxt.step = STEP_STALL;
        end
      end
      STEP_STALL: begin
        if (stalled) begin
          res.command = CMD_STOP;
          nxt.step = STEP_STOP;
        end
      end
      STEP_STOP: begin
        if (word.stop_seen) begin
          if (!nxt.touch_count) begin
            nxt.first_touch = word.measured_position;
            res.command = CMD_MOVE;
            res.command_value = back_tgt[POS_W-1:0];
            nxt.touch_count = 1'b1;
            nxt.step = STEP_BACK;
          end else if (mismatch) begin
            nxt.status_flags[FL_ALARM] = 1'b1;
            res.restore_params = 1'b1;
            nxt.step = STEP_IDLE;
          end else begin
            nxt.settle_count = SETTLE_W'(LONG_SETTLE_TICKS);
            nxt.step = STEP_SETTLE;
          end
        end
      end
      STEP_BACK: begin
        if (word.commanded_position == word.target_position) begin
          nxt.settle_count = SETTLE_W'(SHORT_SETTLE_TICKS);
          nxt.step = STEP_JOG;
        end
      end
      STEP_SETTLE: begin
        if (nxt.settle_count == '0 && word.stop_done) begin
          if (cfg.procedure) begin
            nxt.status_flags = nxt.status_flags | side;
            res.restore_params = 1'b1;
            nxt.step = STEP_IDLE;
          end else begin
            res.command = CMD_MOVE;
            res.command_value = home_tgt[POS_W-1:0];
            nxt.step = STEP_HOME;
          end
        end
      end
      STEP_HOME: begin
        if (word.commanded_position == word.target_position) begin
          res.command = CMD_PRESET;
          res.command_value = cfg.home_position;
          nxt.status_flags[FL_HOMED] = 1'b1;
          res.restore_params = 1'b1;
          nxt.step = STEP_IDLE;
        end
      end
      default: begin
        nxt.step = STEP_IDLE;
      end
    endcase
    res.homed          = nxt.status_flags[FL_HOMED];
    res.homed_negative = nxt.status_flags[FL_NEG];
    res.homed_positive = nxt.status_flags[FL_POS];
    res.alarm          = nxt.status_flags[FL_ALARM];
    res.busy_res       = (nxt.step != STEP_IDLE) && (nxt.step != STEP_START);
  end

endmodule

FILE: design/axis_homing_sequencer_unit.sv
`timescale 1ns / 1ps
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata: tick inputs
// m_axis    out  m_axis_tvalid/tready        tdata: command and status
// cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// One word per clock sustained while m_axis_tready holds; each word passes through the
// input register, then the result register.
// Sequencer state updates when a word leaves the input register.
// rst (synchronous) sends the sequence idle and clears flags, config and result registers.
// A stalled result holds the input register; s_axis_tready falls only when
// both stages are full. cfg_ready is always high.

module axis_homing_sequencer_unit
  import ahs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // start_req, commanded_position, measured_position, target_position,
  // stop_seen, stop_done, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // command, command_value, load_params, restore_params, homed,
  // homed_negative, homed_positive, alarm, busy_res, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  cfg_t   cfg;
  in_t    in_word;
  logic   in_valid;
  state_t state;
  state_t state_next;
  out_t   res_next;
  out_t   res;
  logic   advance;
  in_t    in_unpacked;

  assign in_unpacked.start_req          = s_axis_tdata[0];
  assign in_unpacked.commanded_position = s_axis_tdata[32:1];
  assign in_unpacked.measured_position  = s_axis_tdata[64:33];
  assign in_unpacked.target_position    = s_axis_tdata[96:65];
  assign in_unpacked.stop_seen          = s_axis_tdata[97];
  assign in_unpacked.stop_done          = s_axis_tdata[98];

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  ahs_step_logic u_step (
    .cfg  (cfg),
    .word (in_word),
    .cur  (state),
    .nxt  (state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg                <= '0;
      in_valid           <= 1'b0;
      m_axis_tvalid      <= 1'b0;
      res                <= '0;
      state.step         <= STEP_IDLE;
      state.touch_count  <= 1'b0;
      state.first_touch  <= '0;
      state.settle_count <= '0;
      state.status_flags <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_PROCEDURE:     cfg.procedure        <= cfg_data[0];
          REG_SEARCH_NEG:    cfg.search_negative  <= cfg_data[0];
          REG_STALL_THR:     cfg.stall_threshold  <= cfg_data[30:0];
          REG_MATCH_TOL:     cfg.match_tolerance  <= cfg_data[30:0];
          REG_BACKOFF:       cfg.backoff_distance <= cfg_data[30:0];
          REG_HOME_OFFSET:   cfg.home_offset      <= cfg_data;
          REG_HOME_POSITION: cfg.home_position    <= cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
        in_word  <= in_unpacked;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
        state         <= state_next;
        res           <= res_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {6'b0, res.busy_res, res.alarm, res.homed_positive,
                         res.homed_negative, res.homed, res.restore_params,
                         res.load_params, res.command_value, res.command};

`ifndef SYNTH
  a_no_load_restore: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(res.load_params && res.restore_params))
    else $error("load and restore in one word");

  a_preset_homed: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.command == CMD_PRESET) |-> (res.homed && res.restore_params))
    else $error("preset without homed flag");

  a_held_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("input word lost");

  a_settle_range: assert property (@(posedge clk) disable iff (rst)
    state.settle_count <= SETTLE_W'(LONG_SETTLE_TICKS))
    else $error("settle count out of range");

  a_restore_idle: assert property (@(posedge clk) disable iff (rst)
    advance |=> (!res.restore_params || state.step == STEP_IDLE))
    else $error("restore while busy");
`endif

endmodule
